// File: rtl/double_ended_queue_core_defines.svh
// Assertion helpers shared by the deque RTL
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, disabled while in reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: rtl/deq_pkg.sv
package deq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] NONE_VALUE = '1;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what the back end has to do with the store for one item
    typedef struct packed {
        logic              wr;
        logic              rd;
        t_status           status;
        logic [WORD_W-1:0] data;
    } t_cmd;

endpackage

// File: rtl/deq_ram.sv
module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/deq_front.sv
`include "double_ended_queue_core_defines.svh"

module deq_front
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned IDX_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [WORD_W-1:0] i_push_value,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd,
    output logic [IDX_W-1:0]  o_cmd_addr,
    output logic [CNT_W-1:0]  o_cmd_count
);

    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic             accept;
    logic             full, empty;
    logic [SUM_W-1:0] back_sum, last_sum;
    logic [IDX_W-1:0] back_slot, back_last, front_dec, front_inc;
    t_opcode          op;

    assign op       = t_opcode'(i_opcode);
    assign accept   = i_in_valid && i_cmd_ready;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);

    // ring steps: sums stay below twice the depth, so one compare and subtract wraps
    assign back_sum  = SUM_W'(r_front) + SUM_W'(r_count);
    assign last_sum  = back_sum - SUM_W'(1);
    assign back_slot = (back_sum >= DEPTH_S) ? IDX_W'(back_sum - DEPTH_S) : IDX_W'(back_sum);
    assign back_last = (last_sum >= DEPTH_S) ? IDX_W'(last_sum - DEPTH_S) : IDX_W'(last_sum);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + IDX_W'(1);

    always_comb begin
        n_front          = r_front;
        n_count          = r_count;
        o_cmd.wr         = 1'b0;
        o_cmd.rd         = 1'b0;
        o_cmd.status     = ST_OK;
        o_cmd.data       = i_push_value;
        o_cmd_addr       = r_front;
        case (op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr   = 1'b1;
                    o_cmd_addr = front_dec;
                    n_front    = front_dec;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr   = 1'b1;
                    o_cmd_addr = back_slot;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd   = 1'b1;
                    o_cmd_addr = r_front;
                    n_front    = front_inc;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd   = 1'b1;
                    o_cmd_addr = back_last;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                o_cmd.status = ST_OK;
            end
        endcase
    end

    assign o_cmd_count = n_count;
    assign o_cmd_valid = i_in_valid;
    assign o_in_ready  = i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    `DEQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `DEQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        accept && !i_opcode[1] && !full, r_count == $past(r_count) + CNT_W'(1))
    `DEQ_ASSERT_NEXT(a_empty_pop_holds, i_clk, i_rst_n,
        accept && i_opcode[1] && empty, $stable(r_count) && $stable(r_front))

endmodule

// File: rtl/deq_cmd_queue.sv
module deq_cmd_queue
    import deq_pkg::*;
#(
    parameter int unsigned ADDR_W = 4,
    parameter int unsigned CNT_W  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  t_cmd              i_wr_cmd,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [CNT_W-1:0]  i_wr_count,
    output logic              o_rd_valid,
    input  logic              i_rd_ready,
    output t_cmd              o_rd_cmd,
    output logic [ADDR_W-1:0] o_rd_addr,
    output logic [CNT_W-1:0]  o_rd_count
);

    localparam int unsigned SLOTS = 2;

    t_cmd              r_cmd   [SLOTS];
    logic [ADDR_W-1:0] r_addr  [SLOTS];
    logic [CNT_W-1:0]  r_cnt   [SLOTS];
    logic              r_wptr, r_rptr;
    logic [1:0]        r_fill;
    logic              push, pop;

    assign o_wr_ready = (r_fill != 2'(SLOTS));
    assign o_rd_valid = (r_fill != '0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    assign o_rd_cmd   = r_cmd[r_rptr];
    assign o_rd_addr  = r_addr[r_rptr];
    assign o_rd_count = r_cnt[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wptr]  <= i_wr_cmd;
            r_addr[r_wptr] <= i_wr_addr;
            r_cnt[r_wptr]  <= i_wr_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_fill <= r_fill + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/deq_back.sv
`include "double_ended_queue_core_defines.svh"

module deq_back
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned IDX_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    input  logic [IDX_W-1:0]  i_cmd_addr,
    input  logic [CNT_W-1:0]  i_cmd_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_pop_value,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_count_after,
    output logic              o_now_empty
);

    logic              issue, advance;
    logic [WORD_W-1:0] rdata;

    // stage 1: store access in flight
    logic              r_s1_valid;
    logic              r_s1_rd;
    t_status           r_s1_status;
    logic [CNT_W-1:0]  r_s1_count;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_value;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    assign advance     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign issue       = i_cmd_valid && (!r_s1_valid || advance);
    assign o_cmd_ready = issue;

    // read data holds while stage 1 stalls, since reads are only enabled on issue
    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (issue && i_cmd.wr),
        .i_re    (issue && i_cmd.rd),
        .i_addr  (i_cmd_addr),
        .i_wdata (i_cmd.data),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_rd     <= i_cmd.rd;
            r_s1_status <= i_cmd.status;
            r_s1_count  <= i_cmd_count;
        end
        if (advance) begin
            r_out_value  <= r_s1_rd ? rdata : NONE_VALUE;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pop_value   = r_out_value;
    assign o_status      = r_out_status;
    assign o_count_after = r_out_count;
    assign o_now_empty   = (r_out_count == '0);

    `DEQ_ASSERT_IMPL(a_fail_no_value, i_clk, i_rst_n,
        r_out_valid && (r_out_status != ST_OK), r_out_value == NONE_VALUE)
    `DEQ_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_out_ready, r_s1_valid && $stable(r_s1_count))

endmodule

// File: rtl/double_ended_queue_core.sv
// Bounded deque over a circular store of DEPTH words.
// An accepted item passes the command queue, store access stage and result register.
// One item per cycle while the result side does not stall; the front registers its
// updated indices on accept and the back does one single-port store access per item.
// Reset clears indices, count and all valid flags; store contents are left as they are.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned IDX_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [WORD_W-1:0] i_push_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_pop_value,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_count_after,
    output logic              o_now_empty
);

    logic             f_valid, f_ready;
    t_cmd             f_cmd;
    logic [IDX_W-1:0] f_addr;
    logic [CNT_W-1:0] f_count;

    logic             b_valid, b_ready;
    t_cmd             b_cmd;
    logic [IDX_W-1:0] b_addr;
    logic [CNT_W-1:0] b_count;

    deq_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .o_cmd_valid  (f_valid),
        .i_cmd_ready  (f_ready),
        .o_cmd        (f_cmd),
        .o_cmd_addr   (f_addr),
        .o_cmd_count  (f_count)
    );

    deq_cmd_queue #(
        .ADDR_W (IDX_W),
        .CNT_W  (CNT_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_cmd   (f_cmd),
        .i_wr_addr  (f_addr),
        .i_wr_count (f_count),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd_cmd   (b_cmd),
        .o_rd_addr  (b_addr),
        .o_rd_count (b_count)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (b_valid),
        .o_cmd_ready   (b_ready),
        .i_cmd         (b_cmd),
        .i_cmd_addr    (b_addr),
        .i_cmd_count   (b_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_count_after (o_count_after),
        .o_now_empty   (o_now_empty)
    );

endmodule

// File: sim/deque_result_checker.sv
module deque_result_checker
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned IDX_W = $clog2(DEPTH),
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [WORD_W-1:0] i_push_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_pop_value,
    input  logic [1:0]        i_status,
    input  logic [CNT_W-1:0]  i_count_after,
    input  logic              i_now_empty,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        logic [WORD_W-1:0] pop_value;
        t_status           status;
        logic [CNT_W-1:0]  count_after;
        logic              now_empty;
    } t_deque_result;

    // shadow copy of the deque
    logic [WORD_W-1:0] words [DEPTH];
    logic [IDX_W-1:0]  head = '0;
    logic [CNT_W-1:0]  held = '0;

    t_deque_result awaited_results [$];
    int            fails = 0;

    function automatic t_deque_result apply_deque_op(input logic [1:0] op,
                                                     input logic [WORD_W-1:0] value);
        t_deque_result    r;
        logic [IDX_W-1:0] slot;
        r.pop_value = NONE_VALUE;
        r.status    = ST_OK;
        case (t_opcode'(op))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (held == DEPTH) begin
                    r.status = ST_FULL;
                end else if (t_opcode'(op) == OP_PUSH_FRONT) begin
                    head        = head - 1'b1;
                    words[head] = value;
                    held        = held + 1'b1;
                end else begin
                    slot        = head + held;
                    words[slot] = value;
                    held        = held + 1'b1;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (t_opcode'(op) == OP_POP_FRONT) begin
                    r.pop_value = words[head];
                    head        = head + 1'b1;
                    held        = held - 1'b1;
                end else begin
                    slot        = head + held - 1'b1;
                    r.pop_value = words[slot];
                    held        = held - 1'b1;
                end
            end
        endcase
        r.count_after = held;
        r.now_empty   = (held == 0);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n) begin
            // results are registered after their item is accepted, so compare before predicting
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no item outstanding");
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("pop_value", want.pop_value, i_pop_value);
                    compare_field("status", want.status, i_status);
                    compare_field("count_after", want.count_after, i_count_after);
                    compare_field("now_empty", want.now_empty, i_now_empty);
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_deque_op(i_opcode, i_push_value));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
    end

endmodule

// File: sim/double_ended_queue_core_tb.sv
module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_opcode     = OP_POP_FRONT;
    logic [WORD_W-1:0] i_push_value = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [WORD_W-1:0] o_pop_value;
    logic [1:0]        o_status;
    logic [CNT_W-1:0]  o_count_after;
    logic              o_now_empty;

    int fail_count;
    int pending_results;
    int unsigned items_sent = 0;

    double_ended_queue_core #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_count_after (o_count_after),
        .o_now_empty   (o_now_empty)
    );

    deque_result_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_push_value  (i_push_value),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pop_value   (o_pop_value),
        .i_status      (o_status),
        .i_count_after (o_count_after),
        .i_now_empty   (o_now_empty),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("double_ended_queue_core_tb: FAIL");
        $finish;
    end

    // result side: random back-pressure, one long hold-off, one stretch always ready
    initial begin : result_sink
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 300 && cyc < 420)
                i_out_ready <= 1'b0;
            else if (cyc >= 700 && cyc < 900)
                i_out_ready <= 1'b1;
            else
                i_out_ready <= ($urandom_range(99) >= 32);
        end
    end

    task automatic send_op(input t_opcode op, input logic [WORD_W-1:0] value);
        int unsigned gap;
        gap = 0;
        // no gaps for a stretch in the middle of the random part
        if (items_sent < 450 || items_sent >= 560)
            while ($urandom_range(99) < 32) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_push_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // pending count is registered, hence the leading edge
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int unsigned seg_left;
        int unsigned push_pct;
        logic        is_push;
        seg_left = 0;
        push_pct = 50;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pops on empty, extremes, front index wrapping below zero
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_BACK, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h0000_0000);
        send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        // fill up, then push on full at both ends
        for (int i = 0; i < 14; i++)
            send_op(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                    i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA);
        send_op(OP_PUSH_FRONT, 32'h0F0F_0F0F);
        send_op(OP_PUSH_BACK, 32'hF0F0_F0F0);
        drain_results();

        // segments biased to fill or to empty the queue
        for (int n = 0; n < 750; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            seg_left--;
            is_push = ($urandom_range(99) < push_pct);
            if (is_push)
                send_op($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
            else
                send_op($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, $urandom());
            if (n == 375)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        #1;
        if (fail_count == 0)
            $display("double_ended_queue_core_tb: PASS");
        else
            $display("double_ended_queue_core_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_cmd_queue.sv
rtl/deq_back.sv
rtl/double_ended_queue_core.sv
sim/deque_result_checker.sv
sim/double_ended_queue_core_tb.sv
